// ===== rtl/core/pst_pkg.sv =====
// Shared types and constants of the prefix sum tree.
// Used by pst_ctrl, pst_datapath and prefix_sum_tree.
`default_nettype none

package pst_pkg;

  // Field widths of the item and configuration formats
  localparam int FUNC_W = 3;
  localparam int POS_W  = 10;
  localparam int VAL_W  = 16;
  localparam int SUM_W  = 26;
  localparam int CNT_W  = 11;

  localparam int IN_DATA_W  = 56;  // position, new_value, target_sum, padded to bytes
  localparam int OUT_DATA_W = 56;  // answer, total_sum, padded to bytes

  // Defaults of the top level parameters
  localparam int LEAVES_DEF     = 1024;
  localparam int VALUE_BITS_DEF = 16;

  // Function codes carried in the input tuser
  typedef enum logic [FUNC_W-1:0] {
    FN_SET    = 3'd0,
    FN_PREFIX = 3'd1,
    FN_LOCATE = 3'd2,
    FN_READ   = 3'd3,
    FN_CLEAR  = 3'd4
  } func_e;

  // Datapath commands issued by the controller, one per cycle
  typedef enum logic [3:0] {
    DP_NOP      = 4'd0,
    DP_LOAD     = 4'd1,
    DP_CLR      = 4'd2,
    DP_WR_LEAF  = 4'd3,
    DP_RD_SIB   = 4'd4,
    DP_UP       = 4'd5,
    DP_ACC      = 4'd6,
    DP_RD_LEFT  = 4'd7,
    DP_LOC_STEP = 4'd8,
    DP_RD_NODE  = 4'd9,
    DP_TAKE     = 4'd10,
    DP_OUT      = 4'd11
  } dp_cmd_e;

  // Status returned by the datapath
  typedef struct packed {
    logic [FUNC_W-1:0] func;        // function of the item in flight
    logic              ok;          // operation in range and performed
    logic              up_last;     // parent of the current node is the root
    logic              child_leaf;  // children of the current node are leaves
    logic              clr_last;    // clear sweep at its last entry
    logic              out_free;    // output register can take a result
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/prefix_sum_tree.sv =====
// Items walk the tree level by level: set writes the leaf and updates each parent, prefix
// sum adds left siblings going up, locate steps down from the root; read fetches the leaf,
// clear sweeps the memory, out of range items skip the walk. One item in work at a time:
// the next is taken while the result waits in the output register, which holds the block
// in its last step while the output is stalled. Reset clears the count and sweeps the
// 2*LEAVES node memory, one entry a cycle, before the first item; config writes go on.
`default_nettype none

module prefix_sum_tree
  import pst_pkg::*;
#(
  parameter int LEAVES     = LEAVES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CNT_W-1:0]      cfg_wdata_i,     // num_elements
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,    // position, new_value, target_sum
  input  wire logic [FUNC_W-1:0]     s_axis_tuser,    // func
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,    // answer, total_sum
  output logic                       m_axis_tuser     // answer_valid
);

  dp_cmd_e          cmd;
  dp_status_t       status;
  logic [SUM_W-1:0] answer, total;

  pst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pst_datapath #(
    .LEAVES     (LEAVES),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_func_i          (s_axis_tuser),
    .in_pos_i           (s_axis_tdata[POS_W-1:0]),
    .in_val_i           (s_axis_tdata[POS_W+VAL_W-1:POS_W]),
    .in_target_i        (s_axis_tdata[POS_W+VAL_W+SUM_W-1:POS_W+VAL_W]),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .out_answer_o       (answer),
    .out_answer_valid_o (m_axis_tuser),
    .out_total_o        (total)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - 2*SUM_W){1'b0}}, total, answer};

endmodule

`default_nettype wire

// ===== rtl/core/pst_datapath.sv =====
// Datapath of the prefix sum tree: node memory, walk registers, count
// register and output register. Depends on pst_pkg; driven by pst_ctrl.
`default_nettype none

module pst_datapath
  import pst_pkg::*;
#(
  parameter int LEAVES     = LEAVES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CNT_W-1:0]      cfg_wdata_i,
  input  wire logic [FUNC_W-1:0]     in_func_i,
  input  wire logic [POS_W-1:0]      in_pos_i,
  input  wire logic [VAL_W-1:0]      in_val_i,
  input  wire logic [SUM_W-1:0]      in_target_i,
  input  wire dp_cmd_e               cmd_i,
  output dp_status_t                 status_o,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [SUM_W-1:0]           out_answer_o,
  output logic                       out_answer_valid_o,
  output logic [SUM_W-1:0]           out_total_o
);

  localparam int LeafW  = $clog2(LEAVES);
  localparam int AddrW  = LeafW + 1;
  localparam int Depth  = 2 * LEAVES;
  localparam int CntW   = (LeafW + 1 > CNT_W) ? LeafW + 1 : CNT_W;
  localparam logic [SUM_W-1:0] ValMask = (VALUE_BITS >= SUM_W) ? {SUM_W{1'b1}}
                                         : SUM_W'((64'd1 << VALUE_BITS) - 64'd1);

  // Node memory, 1-based heap: root at 1, leaf i at LEAVES + i
  logic [SUM_W-1:0] mem_q [Depth];
  logic [SUM_W-1:0] rdata_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] waddr, raddr;
  logic [SUM_W-1:0] wdata;

  logic [CNT_W-1:0]  num_q;
  logic [FUNC_W-1:0] func_q;
  logic              ok_q;
  logic              below_q;
  logic [AddrW-1:0]  node_q, node_d;
  logic [SUM_W-1:0]  acc_q, acc_d;
  logic [SUM_W-1:0]  tgt_q, tgt_d;
  logic [SUM_W-1:0]  val_q;
  logic [SUM_W-1:0]  total_q;
  logic [AddrW-1:0]  clr_q;

  logic              out_valid_q;
  logic [SUM_W-1:0]  out_answer_q, out_total_q;
  logic              out_ok_q;

  logic [CntW-1:0]   cnt;
  logic              pos_in_range;
  logic              load_ok;
  logic [CntW-1:0]   loc_idx;
  logic [SUM_W-1:0]  answer;
  logic [AddrW-1:0]  sib_addr, parent_addr, left_addr;

  assign cnt = (CntW'(num_q) > CntW'(LEAVES)) ? CntW'(LEAVES) : CntW'(num_q);
  assign pos_in_range = CntW'(in_pos_i) < cnt;

  always_comb begin
    unique case (in_func_i)
      FN_SET, FN_PREFIX, FN_READ: load_ok = pos_in_range;
      FN_LOCATE:                  load_ok = (cnt != '0);
      FN_CLEAR:                   load_ok = 1'b1;
      default:                    load_ok = 1'b0;
    endcase
  end

  assign sib_addr    = {node_q[AddrW-1:1], ~node_q[0]};
  assign parent_addr = {1'b0, node_q[AddrW-1:1]};
  assign left_addr   = {node_q[AddrW-2:0], 1'b0};

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = node_q;
    raddr  = node_q;
    wdata  = val_q;
    node_d = node_q;
    acc_d  = acc_q;
    tgt_d  = tgt_q;
    unique case (cmd_i)
      DP_LOAD: begin
        node_d = (in_func_i == FN_LOCATE) ? AddrW'(1) : {1'b1, LeafW'(in_pos_i)};
        acc_d  = '0;
        tgt_d  = in_target_i;
      end
      DP_CLR: begin
        mem_we = 1'b1;
        waddr  = clr_q;
        wdata  = '0;
      end
      DP_WR_LEAF: begin
        mem_we = 1'b1;
        acc_d  = val_q;
      end
      DP_RD_SIB: begin
        mem_re = 1'b1;
        raddr  = sib_addr;
      end
      DP_UP: begin
        // sum of the freshly written child and its sibling goes to the parent
        mem_we = 1'b1;
        waddr  = parent_addr;
        wdata  = acc_q + rdata_q;
        acc_d  = acc_q + rdata_q;
        node_d = parent_addr;
      end
      DP_ACC: begin
        // a right child adds its left sibling
        if (node_q[0]) begin
          acc_d = acc_q + rdata_q;
        end
        node_d = parent_addr;
      end
      DP_RD_LEFT: begin
        mem_re = 1'b1;
        raddr  = left_addr;
      end
      DP_LOC_STEP: begin
        if (rdata_q >= tgt_q) begin
          node_d = left_addr;
        end else begin
          tgt_d  = tgt_q - rdata_q;
          node_d = {node_q[AddrW-2:0], 1'b1};
        end
      end
      DP_RD_NODE: begin
        mem_re = 1'b1;
      end
      DP_TAKE: begin
        acc_d = rdata_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    acc_q  <= acc_d;
    tgt_q  <= tgt_d;
    if (cmd_i == DP_LOAD) begin
      func_q  <= in_func_i;
      ok_q    <= load_ok;
      below_q <= total_q < in_target_i;
      val_q   <= SUM_W'(in_val_i) & ValMask;
    end
  end

  // Control registers: count, root mirror, clear sweep pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q   <= '0;
      total_q <= '0;
      clr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        num_q <= cfg_wdata_i;
      end
      if (mem_we && waddr == AddrW'(1)) begin
        total_q <= wdata;
      end
      if (cmd_i == DP_CLR) begin
        clr_q <= clr_q + AddrW'(1);
      end
    end
  end

  // Locate result: saturate to count-1 when the target exceeds the total or the leaf found lies past the count
  assign loc_idx = CntW'(node_q[LeafW-1:0]);

  always_comb begin
    answer = '0;
    if (ok_q) begin
      unique case (func_q)
        FN_SET:            answer = val_q;
        FN_PREFIX, FN_READ: answer = acc_q;
        FN_LOCATE: begin
          if (below_q || loc_idx >= cnt) begin
            answer = SUM_W'(cnt - CntW'(1));
          end else begin
            answer = SUM_W'(loc_idx);
          end
        end
        default:           answer = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i == DP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == DP_OUT) begin
      out_answer_q <= answer;
      out_ok_q     <= ok_q;
      out_total_q  <= total_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_answer_o       = out_answer_q;
  assign out_answer_valid_o = out_ok_q;
  assign out_total_o        = out_total_q;

  assign status_o.func       = func_q;
  assign status_o.ok         = ok_q;
  assign status_o.up_last    = (parent_addr == AddrW'(1));
  assign status_o.child_leaf = node_q[LeafW-1];
  assign status_o.clr_last   = &clr_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== rtl/core/pst_ctrl.sv =====
// Controller of the prefix sum tree: sequences tree walks, clear sweeps
// and result hand-off. Depends on pst_pkg; commands pst_datapath.
`default_nettype none

module pst_ctrl
  import pst_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output dp_cmd_e         cmd_o
);

  typedef enum logic [13:0] {
    S_INIT      = 14'b00000000000001,
    S_IDLE      = 14'b00000000000010,
    S_DISPATCH  = 14'b00000000000100,
    S_WR_LEAF   = 14'b00000000001000,
    S_RD_SIB_UP = 14'b00000000010000,
    S_UP        = 14'b00000000100000,
    S_RD_PRE    = 14'b00000001000000,
    S_ACC       = 14'b00000010000000,
    S_RD_LEFT   = 14'b00000100000000,
    S_LOC       = 14'b00001000000000,
    S_RD_LEAF   = 14'b00010000000000,
    S_TAKE      = 14'b00100000000000,
    S_CLEAR     = 14'b01000000000000,
    S_FINISH    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = DP_NOP;
    unique case (state_q)
      S_INIT: begin
        cmd_o = DP_CLR;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = DP_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!status_i.ok) begin
          state_d = S_FINISH;
        end else begin
          unique case (status_i.func)
            FN_SET:    state_d = S_WR_LEAF;
            FN_PREFIX: state_d = S_RD_PRE;
            FN_LOCATE: state_d = S_RD_LEFT;
            FN_READ:   state_d = S_RD_LEAF;
            FN_CLEAR:  state_d = S_CLEAR;
            default:   state_d = S_FINISH;
          endcase
        end
      end
      S_WR_LEAF: begin
        cmd_o   = DP_WR_LEAF;
        state_d = S_RD_SIB_UP;
      end
      S_RD_SIB_UP: begin
        cmd_o   = DP_RD_SIB;
        state_d = S_UP;
      end
      S_UP: begin
        cmd_o   = DP_UP;
        state_d = status_i.up_last ? S_FINISH : S_RD_SIB_UP;
      end
      S_RD_PRE: begin
        cmd_o   = DP_RD_SIB;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o   = DP_ACC;
        state_d = status_i.up_last ? S_FINISH : S_RD_PRE;
      end
      S_RD_LEFT: begin
        cmd_o   = DP_RD_LEFT;
        state_d = S_LOC;
      end
      S_LOC: begin
        cmd_o   = DP_LOC_STEP;
        state_d = status_i.child_leaf ? S_FINISH : S_RD_LEFT;
      end
      S_RD_LEAF: begin
        cmd_o   = DP_RD_NODE;
        state_d = S_TAKE;
      end
      S_TAKE: begin
        cmd_o   = DP_TAKE;
        state_d = S_FINISH;
      end
      S_CLEAR: begin
        cmd_o = DP_CLR;
        if (status_i.clr_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register frees up
        if (status_i.out_free) begin
          cmd_o   = DP_OUT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

// ===== tb/tb_prefix_sum_tree.sv =====
// Self-checking testbench for prefix_sum_tree: drives set, prefix, locate, read, clear
// and unused function code items over the input stream and checks every result against
// a sum tree kept in the testbench. Depends on pst_pkg and the prefix_sum_tree RTL.
`default_nettype none

module tb_prefix_sum_tree
  import pst_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TREE_LEAVES = LEAVES_DEF;
  localparam int NODES       = 2 * TREE_LEAVES;
  localparam int ITEMS_PER_PHASE = 240;

  // Function codes the block leaves unused
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [SUM_W-1:0] answer;
    logic             ok;
    logic [SUM_W-1:0] total;
  } sum_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [FUNC_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  always #5 clk_i = ~clk_i;

  prefix_sum_tree dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Tree model: 1-based heap, root at 1, leaf i at TREE_LEAVES + i
  logic [SUM_W-1:0] node_sum [NODES];
  logic [CNT_W-1:0] elem_limit = '0;

  sum_result_t pending_answers[$];
  bit          idle_en = 1'b1;
  int unsigned stall_left = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned items_done = 0;
  int unsigned results_seen = 0;
  int unsigned counts_used = 0;

  function automatic int unsigned live_count();
    return (elem_limit > TREE_LEAVES) ? TREE_LEAVES : int'(elem_limit);
  endfunction

  function automatic sum_result_t tree_apply(logic [FUNC_W-1:0] fn, logic [POS_W-1:0] pos,
                                             logic [VAL_W-1:0] val,
                                             logic [SUM_W-1:0] target);
    sum_result_t r;
    int unsigned cnt;
    int unsigned node;
    int unsigned idx;
    logic [SUM_W-1:0] acc;
    logic [SUM_W-1:0] rest;
    r = '0;
    cnt = live_count();
    case (fn)
      FN_SET: begin
        if (pos < cnt) begin
          node = TREE_LEAVES + pos;
          node_sum[node] = SUM_W'(val);
          while (node > 1) begin
            node = node / 2;
            node_sum[node] = node_sum[2*node] + node_sum[2*node+1];
          end
          r.answer = SUM_W'(val);
          r.ok = 1'b1;
        end
      end
      FN_PREFIX: begin
        if (pos < cnt) begin
          acc = '0;
          node = TREE_LEAVES + pos;
          // add the left sibling whenever we climb from a right child
          while (node > 1) begin
            if (node % 2 == 1) acc = acc + node_sum[node-1];
            node = node / 2;
          end
          r.answer = acc;
          r.ok = 1'b1;
        end
      end
      FN_LOCATE: begin
        if (cnt > 0) begin
          if (node_sum[1] < target) begin
            idx = cnt - 1;
          end else begin
            node = 1;
            rest = target;
            while (node < TREE_LEAVES) begin
              if (node_sum[2*node] >= rest) begin
                node = 2 * node;
              end else begin
                rest = rest - node_sum[2*node];
                node = 2 * node + 1;
              end
            end
            idx = node - TREE_LEAVES;
            if (idx >= cnt) idx = cnt - 1;
          end
          r.answer = SUM_W'(idx);
          r.ok = 1'b1;
        end
      end
      FN_READ: begin
        if (pos < cnt) begin
          r.answer = node_sum[TREE_LEAVES + pos];
          r.ok = 1'b1;
        end
      end
      FN_CLEAR: begin
        foreach (node_sum[i]) node_sum[i] = '0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.total = node_sum[1];
    return r;
  endfunction

  task automatic send_item(logic [FUNC_W-1:0] fn, logic [POS_W-1:0] pos,
                           logic [VAL_W-1:0] val, logic [SUM_W-1:0] target);
    sum_result_t r;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= IN_DATA_W'({target, val, pos});
    do @(posedge clk_i); while (!s_axis_tready);
    r = tree_apply(fn, pos, val, target);
    pending_answers.push_back(r);
    items_sent++;
    if (r.ok) items_done++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_count(logic [CNT_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    elem_limit = value;
    counts_used++;
  endtask

  // Result checker and receiver stalls
  always @(posedge clk_i) begin
    sum_result_t exp_r;
    logic [SUM_W-1:0] got_answer;
    logic [SUM_W-1:0] got_total;
    got_answer = m_axis_tdata[SUM_W-1:0];
    got_total  = m_axis_tdata[2*SUM_W-1:SUM_W];
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual answer %0d ok %0b total %0d",
                 $time, got_answer, m_axis_tuser, got_total);
        mismatch_cnt++;
      end else begin
        exp_r = pending_answers.pop_front();
        if (got_answer !== exp_r.answer) begin
          $display("%0t: answer mismatch, expected %0d, actual %0d",
                   $time, exp_r.answer, got_answer);
          mismatch_cnt++;
        end
        if (m_axis_tuser !== exp_r.ok) begin
          $display("%0t: answer_valid mismatch, expected %0b, actual %0b",
                   $time, exp_r.ok, m_axis_tuser);
          mismatch_cnt++;
        end
        if (got_total !== exp_r.total) begin
          $display("%0t: total_sum mismatch, expected %0d, actual %0d",
                   $time, exp_r.total, got_total);
          mismatch_cnt++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // No elements in use: every indexed operation and locate come back empty
  task automatic test_empty_tree();
    set_count('0);
    send_item(FN_LOCATE, '0, '0, '0);
    send_item(FN_PREFIX, '0, '0, '0);
    send_item(FN_READ, '1, '0, SUM_MAX);
    send_item(FN_SET, '0, VAL_MAX, '0);
    for (int c = FN_SPARE_LO; c <= FN_SPARE_HI; c++) begin
      send_item(FUNC_W'(c), '1, VAL_MAX, SUM_MAX);
    end
    send_item(FN_CLEAR, '0, '0, '0);
  endtask

  // Count above the leaf count saturates; extreme positions, values and targets
  task automatic test_extremes();
    set_count(CNT_MAX);
    send_item(FN_SET, '0, VAL_MAX, '0);
    send_item(FN_SET, '1, VAL_MAX, '0);
    send_item(FN_SET, POS_W'(TREE_LEAVES / 2), VAL_W'(1), '0);
    send_item(FN_PREFIX, '0, '0, '0);
    send_item(FN_PREFIX, '1, '0, '0);
    send_item(FN_READ, '1, '0, '0);
    send_item(FN_LOCATE, '0, '0, '0);
    send_item(FN_LOCATE, '0, '0, node_sum[1]);
    send_item(FN_LOCATE, '0, '0, node_sum[1] + 1'b1);
    send_item(FN_LOCATE, '0, '0, SUM_MAX);
    send_item(FN_READ, POS_W'(TREE_LEAVES / 2), '0, '0);
    send_item(FN_SPARE_HI, '0, '0, '0);
  endtask

  // Shrunk count: stale leaves still count, locate saturates to the last element
  task automatic test_shrunk_count();
    set_count(CNT_W'(1));
    send_item(FN_PREFIX, '0, '0, '0);
    send_item(FN_LOCATE, '0, '0, SUM_MAX);
    send_item(FN_LOCATE, '0, '0, SUM_W'(VAL_MAX) + 1'b1);
    send_item(FN_SET, POS_W'(1), VAL_W'(7), '0);
    send_item(FN_READ, '0, '0, '0);
  endtask

  task automatic test_random_mix(logic [CNT_W-1:0] count, int unsigned n_done,
                                 int unsigned n_cap);
    int unsigned cnt;
    int unsigned pick;
    int unsigned done0;
    int unsigned sent0;
    logic [FUNC_W-1:0] fn;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    logic [SUM_W-1:0]  tgt;
    set_count(count);
    cnt   = live_count();
    done0 = items_done;
    sent0 = items_sent;
    while (items_done - done0 < n_done && items_sent - sent0 < n_cap) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      fn = FN_SET;
      else if (pick < 58) fn = FN_PREFIX;
      else if (pick < 76) fn = FN_LOCATE;
      else if (pick < 92) fn = FN_READ;
      else if (pick < 93) fn = FN_CLEAR;
      else if (pick < 96) fn = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
      else                fn = FN_PREFIX;
      if (cnt > 0 && $urandom_range(0, 9) != 0) pos = POS_W'($urandom_range(0, cnt - 1));
      else pos = POS_W'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 2)       val = VAL_MAX;
      else if (pick == 2) val = '0;
      else                val = VAL_W'($urandom);
      // mostly targets within reach of the total, some past it
      pick = $urandom_range(0, 19);
      if (pick == 0)      tgt = '0;
      else if (pick < 3)  tgt = SUM_W'($urandom);
      else if (pick == 3) tgt = SUM_MAX;
      else                tgt = SUM_W'($urandom_range(0, int'(node_sum[1]) + 16));
      send_item(fn, pos, val, tgt);
    end
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    test_random_mix(CNT_W'(TREE_LEAVES), ITEMS_PER_PHASE, ITEMS_PER_PHASE * 4);
  endtask

  initial begin
    foreach (node_sum[i]) node_sum[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_tree();
    test_extremes();
    test_shrunk_count();
    test_random_mix(CNT_W'(TREE_LEAVES), ITEMS_PER_PHASE, ITEMS_PER_PHASE * 4);
    test_random_mix(CNT_W'(3), ITEMS_PER_PHASE, ITEMS_PER_PHASE * 4);
    test_random_mix(CNT_W'(2), ITEMS_PER_PHASE, ITEMS_PER_PHASE * 4);
    test_random_mix(CNT_W'(64), ITEMS_PER_PHASE, ITEMS_PER_PHASE * 4);
    test_random_mix(CNT_W'(1), ITEMS_PER_PHASE, ITEMS_PER_PHASE * 4);
    test_random_mix(CNT_W'($urandom_range(4, TREE_LEAVES - 1)), ITEMS_PER_PHASE,
                    ITEMS_PER_PHASE * 4);
    // empty tree again: only clears are performed, keep it short
    test_random_mix('0, 30, 30);
    test_back_to_back();

    drain_results();
    repeat (30) @(posedge clk_i);
    $display("Sent %0d items (%0d performed) over %0d element counts; checked %0d results",
             items_sent, items_done, counts_used, results_seen);
    if (mismatch_cnt == 0 && pending_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
